// ===== rtl/core/laplace_5x5_edge_filter_core_assert.svh =====
// Assertion macros for the Laplacian edge filter core.
// Used by lef_back in rtl/core; depends on nothing else.
`ifndef LAPLACE_5X5_EDGE_FILTER_CORE_ASSERT_SVH
`define LAPLACE_5X5_EDGE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LEF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lef: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lef: next-cycle check failed");

`endif

// ===== rtl/core/lef_pkg.sv =====
// Shared constants, codes and types of the Laplacian edge filter core.
// No dependencies; the modules in rtl/core use it by scoped names.
package lef_pkg;

   // Line store geometry
   localparam int MAX_WIDTH   = 2048;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int PIX_W       = 8;
   localparam int LINE_ROWS   = 4;
   localparam int WORD_W      = LINE_ROWS * PIX_W;
   localparam int WIN_N       = 5;

   // Configuration registers
   localparam int WID_W       = 12;
   localparam int HGT_W       = 16;
   localparam int DRAIN_W     = WID_W + 1;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [WID_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [WID_W-1:0] WIDTH_MIN    = 12'd5;
   localparam logic [WID_W-1:0] WIDTH_MAX    = WID_W'(MAX_WIDTH);
   localparam logic [HGT_W-1:0] HEIGHT_RESET = 16'd480;
   localparam logic [HGT_W-1:0] HEIGHT_MIN   = 16'd5;

   // Input operation codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // Filter arithmetic: 24 * centre - neighbours = 25 * centre - all 25
   localparam int CENTER_GAIN = 25;
   localparam int ROW_SUM_W   = 11;
   localparam int TOTAL_W     = 13;
   localparam int DIFF_W      = TOTAL_W + 1;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // Command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef logic [PIX_W-1:0] pix_type;

   // One classified word from the front to the back
   typedef struct packed {
      logic             push;
      logic             emit;
      pix_type          pixel;
      logic [COL_W-1:0] column;
   } cmd_type;

   // Frame geometry and restart strobe from the front to the back
   typedef struct packed {
      logic             restart;
      logic [WID_W-1:0] width;
      logic [HGT_W-1:0] height;
   } ctrl_type;

endpackage

// ===== rtl/core/lef_front.sv =====
// Front end: configuration registers, input raster position and
// classification of each accepted word into a command. Uses lef_pkg.
module lef_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [lef_pkg::PIX_W-1:0]       req_pixel_value,
   input  logic                            csr_write_enable,
   input  logic [lef_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lef_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            queue_full,
   input  logic                            clear_busy,
   output logic                            queue_push,
   output lef_pkg::cmd_type                queue_cmd,
   output lef_pkg::ctrl_type               ctrl
);

   logic [lef_pkg::WID_W-1:0]   width_ff, width_in, width_eff;
   logic [lef_pkg::HGT_W-1:0]   height_ff, height_in, height_eff;
   logic [lef_pkg::COL_W-1:0]   in_col_ff, in_col_in;
   logic [lef_pkg::HGT_W-1:0]   in_row_ff, in_row_in;
   logic [lef_pkg::DRAIN_W-1:0] drain_ff, drain_in;
   logic                        accept, draining, due, col_wrap, drain_end, restart;
   logic [lef_pkg::WID_W-1:0]   col_next;

   // Clamp the geometry to its working range
   always_comb begin
      width_eff = width_ff;
      if (width_ff < lef_pkg::WIDTH_MIN) begin
         width_eff = lef_pkg::WIDTH_MIN;
      end else if (width_ff > lef_pkg::WIDTH_MAX) begin
         width_eff = lef_pkg::WIDTH_MAX;
      end
      height_eff = (height_ff < lef_pkg::HEIGHT_MIN) ? lef_pkg::HEIGHT_MIN : height_ff;
   end

   // Classify the current word
   assign req_ready = !queue_full && !clear_busy;
   assign accept    = req_valid && req_ready;
   assign draining  = in_row_ff >= height_eff;
   assign due       = (in_row_ff > 16'd2) || ((in_row_ff == 16'd2) && (in_col_ff >= 11'd2));
   assign col_next  = {1'b0, in_col_ff} + 12'd1;
   assign col_wrap  = col_next >= width_eff;
   assign drain_end = drain_ff == {width_eff, 1'b1};
   assign restart   = csr_write_enable &&
                      ((csr_index == lef_pkg::REG_FRAME_WIDTH) ||
                       (csr_index == lef_pkg::REG_FRAME_HEIGHT));

   assign queue_push       = accept && (draining || (req_op == lef_pkg::OP_PIXEL));
   assign queue_cmd.push   = !draining;
   assign queue_cmd.emit   = draining || due;
   assign queue_cmd.pixel  = req_pixel_value;
   assign queue_cmd.column = in_col_ff;

   assign ctrl.restart = restart;
   assign ctrl.width   = width_eff;
   assign ctrl.height  = height_eff;

   // Advance the raster position and the drain count
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      in_col_in = in_col_ff;
      in_row_in = in_row_ff;
      drain_in  = drain_ff;
      if (restart) begin
         if (csr_index == lef_pkg::REG_FRAME_WIDTH) begin
            width_in = csr_data[lef_pkg::WID_W-1:0];
         end else begin
            height_in = csr_data;
         end
         in_col_in = '0;
         in_row_in = '0;
         drain_in  = '0;
      end else if (accept) begin
         if (draining) begin
            if (drain_end) begin
               in_col_in = '0;
               in_row_in = '0;
               drain_in  = '0;
            end else begin
               drain_in = drain_ff + 13'd1;
            end
         end else if (req_op == lef_pkg::OP_PIXEL) begin
            if (col_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 16'd1;
            end else begin
               in_col_in = col_next[lef_pkg::COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lef_pkg::WIDTH_RESET;
         height_ff <= lef_pkg::HEIGHT_RESET;
         in_col_ff <= '0;
         in_row_ff <= '0;
         drain_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         in_col_ff <= in_col_in;
         in_row_ff <= in_row_in;
         drain_ff  <= drain_in;
      end
   end

endmodule

// ===== rtl/core/lef_queue.sv =====
// Short command queue between the front and the back of the filter core.
// Uses lef_pkg for the command type and depth.
module lef_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lef_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output lef_pkg::cmd_type pop_cmd
);

   lef_pkg::cmd_type          entry_ff [lef_pkg::QUEUE_DEPTH];
   logic [lef_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [lef_pkg::QPTR_W:0]   count_ff, count_in;
   logic                       do_push, do_pop;

   assign full      = count_ff == (lef_pkg::QPTR_W + 1)'(lef_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the word
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/lef_back.sv =====
// Back end: line store, 5x5 window, adder tree, output position and result
// register of the filter core. Uses lef_pkg and the assertion macro header.
`include "laplace_5x5_edge_filter_core_assert.svh"

module lef_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lef_pkg::ctrl_type         ctrl,
   input  logic                      queue_valid,
   input  lef_pkg::cmd_type          queue_cmd,
   output logic                      queue_pop,
   output logic                      clear_busy,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [lef_pkg::PIX_W-1:0] rsp_edge_value,
   output logic                      rsp_end_of_frame
);

   // Line store: four rows packed in one word per column, newest row low
   logic [lef_pkg::WORD_W-1:0] line_mem [lef_pkg::MAX_WIDTH];
   logic [lef_pkg::WORD_W-1:0] rd_word_ff, mem_wdata;
   logic [lef_pkg::COL_W-1:0]  mem_waddr;
   logic                       mem_we;
   logic [lef_pkg::COL_W:0]    clr_cnt_ff, clr_cnt_in;

   logic                       adv, a_vld_ff, a_step, pos_step;
   lef_pkg::cmd_type           a_cmd_ff;
   lef_pkg::pix_type           win_ff [lef_pkg::WIN_N][lef_pkg::WIN_N];
   lef_pkg::pix_type           win_in [lef_pkg::WIN_N][lef_pkg::WIN_N];
   lef_pkg::pix_type           col_pix [lef_pkg::WIN_N];

   logic [lef_pkg::COL_W-1:0]  out_col_ff, out_col_in;
   logic [lef_pkg::HGT_W-1:0]  out_row_ff, out_row_in;
   logic [lef_pkg::WID_W-1:0]  col_ext, col_plus1, col_plus2;
   logic [lef_pkg::HGT_W:0]    row_plus1, row_plus2;
   logic                       border, last;

   logic                       b_vld_ff, b_emit_ff, b_border_ff, b_last_ff;
   logic                       c_vld_ff, c_emit_ff, c_border_ff, c_last_ff;
   lef_pkg::pix_type           c_center_ff;
   logic [lef_pkg::ROW_SUM_W-1:0] c_row_ff [lef_pkg::WIN_N];
   logic [lef_pkg::ROW_SUM_W-1:0] row_sum [lef_pkg::WIN_N];

   logic [lef_pkg::TOTAL_W-1:0] total, gain;
   logic signed [lef_pkg::DIFF_W-1:0] diff;
   lef_pkg::pix_type           clamped, edge_in;
   logic                       rsp_valid_ff, rsp_eof_ff;
   lef_pkg::pix_type           rsp_edge_ff;

   // Advance the whole pipeline whenever the result register can take a word
   assign adv        = !rsp_valid_ff || rsp_ready;
   assign clear_busy = !clr_cnt_ff[lef_pkg::COL_W];
   assign queue_pop  = adv && queue_valid && !clear_busy;
   assign a_step     = adv && a_vld_ff && a_cmd_ff.push;
   assign pos_step   = adv && a_vld_ff && a_cmd_ff.emit;

   // Sweep zeros through the line store after reset
   assign clr_cnt_in = clear_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // Rotate the column: oldest row drops, the new pixel enters low
   assign mem_we    = clear_busy || a_step;
   assign mem_waddr = clear_busy ? clr_cnt_ff[lef_pkg::COL_W-1:0] : a_cmd_ff.column;
   assign mem_wdata = clear_busy ? '0 :
                      {rd_word_ff[lef_pkg::WORD_W-lef_pkg::PIX_W-1:0], a_cmd_ff.pixel};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      if (adv) begin
         rd_word_ff <= line_mem[queue_cmd.column];
      end
   end

   // Stage A: command with its line store column
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= queue_valid && !clear_busy;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_cmd_ff <= queue_cmd;
      end
   end

   // Shift the window left by one column, oldest row first
   assign col_pix[0] = rd_word_ff[31:24];
   assign col_pix[1] = rd_word_ff[23:16];
   assign col_pix[2] = rd_word_ff[15:8];
   assign col_pix[3] = rd_word_ff[7:0];
   assign col_pix[4] = a_cmd_ff.pixel;

   always_comb begin
      for (int r = 0; r < lef_pkg::WIN_N; r++) begin
         for (int k = 0; k < lef_pkg::WIN_N - 1; k++) begin
            win_in[r][k] = a_step ? win_ff[r][k+1] : win_ff[r][k];
         end
         win_in[r][lef_pkg::WIN_N-1] = a_step ? col_pix[r] : win_ff[r][lef_pkg::WIN_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < lef_pkg::WIN_N; r++) begin
            for (int k = 0; k < lef_pkg::WIN_N; k++) begin
               win_ff[r][k] <= '0;
            end
         end
      end else begin
         win_ff <= win_in;
      end
   end

   // Classify the output position: border and end of frame
   assign col_ext   = {1'b0, out_col_ff};
   assign col_plus1 = col_ext + 12'd1;
   assign col_plus2 = col_ext + 12'd2;
   assign row_plus1 = {1'b0, out_row_ff} + 17'd1;
   assign row_plus2 = {1'b0, out_row_ff} + 17'd2;
   assign border    = !((out_row_ff >= 16'd2) && (row_plus2 < {1'b0, ctrl.height}) &&
                        (out_col_ff >= 11'd2) && (col_plus2 < ctrl.width));
   assign last      = (row_plus1 >= {1'b0, ctrl.height}) && (col_plus1 >= ctrl.width);

   always_comb begin
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (ctrl.restart || (pos_step && last)) begin
         out_col_in = '0;
         out_row_in = '0;
      end else if (pos_step) begin
         if (col_plus1 >= ctrl.width) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 16'd1;
         end else begin
            out_col_in = col_plus1[lef_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // Stage B: window now holds this word's neighbourhood
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_emit_ff   <= a_cmd_ff.emit;
         b_border_ff <= border;
         b_last_ff   <= last;
      end
   end

   // Sum each window row
   always_comb begin
      for (int r = 0; r < lef_pkg::WIN_N; r++) begin
         row_sum[r] = '0;
         for (int k = 0; k < lef_pkg::WIN_N; k++) begin
            row_sum[r] = row_sum[r] + lef_pkg::ROW_SUM_W'(win_ff[r][k]);
         end
      end
   end

   // Stage C: row sums and centre
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_emit_ff   <= b_emit_ff;
         c_border_ff <= b_border_ff;
         c_last_ff   <= b_last_ff;
         c_center_ff <= win_ff[2][2];
         c_row_ff    <= row_sum;
      end
   end

   // Combine rows, clamp to a pixel and invert; border positions give PIX_MAX
   always_comb begin
      total = '0;
      for (int r = 0; r < lef_pkg::WIN_N; r++) begin
         total = total + lef_pkg::TOTAL_W'(c_row_ff[r]);
      end
      gain = lef_pkg::TOTAL_W'(c_center_ff) * lef_pkg::TOTAL_W'(lef_pkg::CENTER_GAIN);
      diff = $signed({1'b0, gain}) - $signed({1'b0, total});
      if (diff[lef_pkg::DIFF_W-1]) begin
         clamped = '0;
      end else if (diff > $signed(lef_pkg::DIFF_W'(lef_pkg::PIX_MAX))) begin
         clamped = lef_pkg::PIX_MAX;
      end else begin
         clamped = diff[lef_pkg::PIX_W-1:0];
      end
      edge_in = c_border_ff ? lef_pkg::PIX_MAX : lef_pkg::PIX_MAX - clamped;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= c_vld_ff && c_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_edge_ff <= edge_in;
         rsp_eof_ff  <= c_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_edge_value   = rsp_edge_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

   // Checks
   `LEF_ASSERT_IMP(a_clear_idle, clock, reset, clear_busy, !a_vld_ff && !rsp_valid_ff)
   `LEF_ASSERT_IMP(a_col_in_range, clock, reset, 1'b1, col_ext < ctrl.width)
   `LEF_ASSERT_NEXT(a_last_restarts, clock, reset, pos_step && last, out_col_ff == '0 && out_row_ff == '0)
   `LEF_ASSERT_NEXT(a_drain_keeps_window, clock, reset, adv && a_vld_ff && !a_cmd_ff.push, $stable(win_ff[2][2]))

endmodule

// ===== rtl/core/laplace_5x5_edge_filter_core.sv =====
// Top level of the 5x5 Laplacian edge filter core.
// Depends on lef_pkg, lef_front, lef_queue and lef_back.
//
//   channel  direction  handshake                     payload
//   req      in         req_valid / req_ready         req_op, req_pixel_value
//   rsp      out        rsp_valid / rsp_ready         rsp_edge_value, rsp_end_of_frame
//   csr      in         csr_write_enable (no wait)    csr_index, csr_data
//
// Sustained rate is one word per clock while results are taken; the line store
// read-modify-write sits in the back pipeline, one read and one write port per cycle.
// From acceptance, a word passes the queue exit with the store read, the window,
// the row sums and the result register before its result is valid.
// After reset a clearing pass zeros all 2048 line store words; req_ready is low.
// A stalled result stalls the back; the front keeps taking words until the
// four-entry queue fills.
module laplace_5x5_edge_filter_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic [lef_pkg::PIX_W-1:0]       req_pixel_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lef_pkg::PIX_W-1:0]       rsp_edge_value,
   output logic                            rsp_end_of_frame,
   input  logic                            csr_write_enable,
   input  logic [lef_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lef_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic              queue_push, queue_full, queue_pop, queue_valid, clear_busy;
   lef_pkg::cmd_type  push_cmd, pop_cmd;
   lef_pkg::ctrl_type ctrl;

   // Accept and classify
   lef_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_pixel_value  (req_pixel_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .queue_full       (queue_full),
      .clear_busy       (clear_busy),
      .queue_push       (queue_push),
      .queue_cmd        (push_cmd),
      .ctrl             (ctrl)
   );

   // Decouple front from back
   lef_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_cmd   (pop_cmd)
   );

   // Filter and deliver
   lef_back u_back (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .queue_valid      (queue_valid),
      .queue_cmd        (pop_cmd),
      .queue_pop        (queue_pop),
      .clear_busy       (clear_busy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_edge_value   (rsp_edge_value),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

endmodule
